>>> sv/ess_pkg.sv
// ----------------------------------------------------------------------------
// ess_pkg
// Types, codes, sine table and helpers for the envelope segment step
// ----------------------------------------------------------------------------
package ess_pkg;

   localparam logic [2:0] CMD_EXP    = 3'd0;
   localparam logic [2:0] CMD_INVEXP = 3'd1;
   localparam logic [2:0] CMD_LINEAR = 3'd2;
   localparam logic [2:0] CMD_SINE   = 3'd3;
   localparam logic [2:0] CMD_JUMP   = 3'd4;

   localparam logic [1:0] DIR_RISE = 2'd0;
   localparam logic [1:0] DIR_FALL = 2'd1;

   localparam int SINE_ENTRIES = 256;
   // three radix 2^14 digit stages cover the 41-bit scaled magnitude
   localparam int DIV_STAGES   = 3;
   localparam int DIV_STEPS    = 14;
   localparam int DIV_WIDTH    = DIV_STAGES * DIV_STEPS;
   localparam logic [7:0] DIV_BY = 8'd125;
   // ceil(2^28 / 125), exact for every partial dividend below 125 * 2^14
   localparam logic [21:0] DIV_RECIP = 22'd2147484;
   localparam int DIV_SHIFT = 28;
   // any product above this magnitude saturates every kind anyway
   localparam logic [65:0] PROD_CAP = 66'd17179869184000;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [1:0]         direction;
      logic signed [31:0] current_factor;
      logic signed [31:0] param_one;
      logic signed [31:0] param_two;
      logic [7:0]         phase_step;
      logic signed [31:0] target_factor;
      logic signed [8:0]  sine_phase;
   } req_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [1:0]         direction;
      logic signed [31:0] base;
      logic signed [31:0] target;
      logic signed [31:0] offset;
      logic signed [8:0]  phase;
      logic               rate_small;
   } sb_type;

   localparam logic [18:0] HALF_SINE [SINE_ENTRIES] = '{
      19'd0, 19'd6135, 19'd12270, 19'd18403, 19'd24533, 19'd30660, 19'd36782, 19'd42898,
      19'd49008, 19'd55111, 19'd61205, 19'd67290, 19'd73365, 19'd79429, 19'd85480, 19'd91519,
      19'd97545, 19'd103555, 19'd109550, 19'd115529, 19'd121490, 19'd127432, 19'd133356,
      19'd139259, 19'd145142, 19'd151002, 19'd156840, 19'd162655, 19'd168444, 19'd174209,
      19'd179947, 19'd185658, 19'd191341, 19'd196996, 19'd202620, 19'd208214, 19'd213777,
      19'd219308, 19'd224805, 19'd230269, 19'd235698, 19'd241091, 19'd246449, 19'd251769,
      19'd257051, 19'd262294, 19'd267498, 19'd272662, 19'd277785, 19'd282865, 19'd287904,
      19'd292898, 19'd297849, 19'd302755, 19'd307615, 19'd312429, 19'd317196, 19'd321915,
      19'd326586, 19'd331207, 19'd335779, 19'd340300, 19'd344770, 19'd349188, 19'd353553,
      19'd357865, 19'd362123, 19'd366327, 19'd370475, 19'd374568, 19'd378604, 19'd382583,
      19'd386505, 19'd390368, 19'd394173, 19'd397918, 19'd401603, 19'd405228, 19'd408792,
      19'd412294, 19'd415734, 19'd419112, 19'd422426, 19'd425677, 19'd428864, 19'd431986,
      19'd435043, 19'd438035, 19'd440960, 19'd443819, 19'd446612, 19'd449337, 19'd451994,
      19'd454583, 19'd457104, 19'd459556, 19'd461939, 19'd464253, 19'd466496, 19'd468669,
      19'd470772, 19'd472803, 19'd474764, 19'd476653, 19'd478470, 19'd480215, 19'd481888,
      19'd483488, 19'd485015, 19'd486469, 19'd487851, 19'd489158, 19'd490392, 19'd491552,
      19'd492638, 19'd493650, 19'd494588, 19'd495451, 19'd496239, 19'd496953, 19'd497592,
      19'd498156, 19'd498645, 19'd499059, 19'd499397, 19'd499661, 19'd499849, 19'd499962,
      19'd500000, 19'd499962, 19'd499849, 19'd499661, 19'd499397, 19'd499059, 19'd498645,
      19'd498156, 19'd497592, 19'd496953, 19'd496239, 19'd495451, 19'd494588, 19'd493650,
      19'd492638, 19'd491552, 19'd490392, 19'd489158, 19'd487851, 19'd486469, 19'd485015,
      19'd483488, 19'd481888, 19'd480215, 19'd478470, 19'd476653, 19'd474764, 19'd472803,
      19'd470772, 19'd468669, 19'd466496, 19'd464253, 19'd461939, 19'd459556, 19'd457104,
      19'd454583, 19'd451994, 19'd449337, 19'd446612, 19'd443819, 19'd440960, 19'd438035,
      19'd435043, 19'd431986, 19'd428864, 19'd425677, 19'd422426, 19'd419112, 19'd415734,
      19'd412294, 19'd408792, 19'd405228, 19'd401603, 19'd397918, 19'd394173, 19'd390368,
      19'd386505, 19'd382583, 19'd378604, 19'd374568, 19'd370475, 19'd366327, 19'd362123,
      19'd357865, 19'd353553, 19'd349188, 19'd344770, 19'd340300, 19'd335779, 19'd331207,
      19'd326586, 19'd321915, 19'd317196, 19'd312429, 19'd307615, 19'd302755, 19'd297849,
      19'd292898, 19'd287904, 19'd282865, 19'd277785, 19'd272662, 19'd267498, 19'd262294,
      19'd257051, 19'd251769, 19'd246449, 19'd241091, 19'd235698, 19'd230269, 19'd224805,
      19'd219308, 19'd213777, 19'd208214, 19'd202620, 19'd196996, 19'd191341, 19'd185658,
      19'd179947, 19'd174209, 19'd168444, 19'd162655, 19'd156840, 19'd151002, 19'd145142,
      19'd139259, 19'd133356, 19'd127432, 19'd121490, 19'd115529, 19'd109550, 19'd103555,
      19'd97545, 19'd91519, 19'd85480, 19'd79429, 19'd73365, 19'd67290, 19'd61205, 19'd55111,
      19'd49008, 19'd42898, 19'd36782, 19'd30660, 19'd24533, 19'd18403, 19'd12270, 19'd6135
   };

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      logic signed [31:0] r;
      if (v > 38'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -38'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> sv/ess_if.sv
// ----------------------------------------------------------------------------
// ess_if
// Request and response channels of the envelope segment step
// ----------------------------------------------------------------------------
interface ess_req_if;
   import ess_pkg::*;
   logic               valid;
   logic               ready;
   logic [2:0]         cmd;
   logic [1:0]         direction;
   logic signed [31:0] current_factor;
   logic signed [31:0] param_one;
   logic signed [31:0] param_two;
   logic [7:0]         phase_step;
   logic signed [31:0] target_factor;
   logic signed [8:0]  sine_phase;
   modport source (output valid, cmd, direction, current_factor, param_one, param_two,
                   phase_step, target_factor, sine_phase, input ready);
   modport sink (input valid, cmd, direction, current_factor, param_one, param_two,
                 phase_step, target_factor, sine_phase, output ready);
endinterface

interface ess_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_factor;
   logic signed [8:0]  new_phase;
   logic               reached;
   modport source (output valid, new_factor, new_phase, reached, input ready);
   modport sink (input valid, new_factor, new_phase, reached, output ready);
endinterface

>>> sv/envelope_segment_step_top.sv
// ----------------------------------------------------------------------------
// envelope_segment_step_top
// One envelope segment update per transaction, fully pipelined
// ----------------------------------------------------------------------------
// a request passes through these registers in order before its response is valid
// (input, operand, product, magnitude, three divide-by-125 digit stages, output)
// throughput: one transaction per cycle unless the response is stalled;
// stalled stages hold, empty stages fill while the response waits
// synchronous active-high reset clears all valid bits; payload is not reset
module envelope_segment_step_top (
   input  logic        clock,
   input  logic        reset,
   ess_req_if.sink     req_ch,
   ess_rsp_if.source   rsp_ch
);
   import ess_pkg::*;

   localparam int NS = 4 + DIV_STAGES;

   logic [NS-1:0] v_ff;
   logic [NS:0]   rdy;
   logic          ov_ff;

   req_type            in_ff;
   req_type            in_in;
   sb_type             sb_ff [1:NS-1];
   sb_type             prep_sb;
   logic signed [33:0] op_a_ff, op_a_in;
   logic signed [31:0] op_b_ff, op_b_in;
   logic signed [65:0] prod_ff;
   logic [65:0]        mag;
   logic [65:0]        capped;
   logic               neg_ff [3:NS-1];
   logic [6:0]         rem_ff [3:NS-1];
   logic [DIV_WIDTH-1:0] x_ff [3:NS-1];
   logic [6:0]         rem_in [DIV_STAGES];
   logic [DIV_WIDTH-1:0] x_in [DIV_STAGES];

   logic signed [31:0] fin_factor;
   logic               fin_reached;
   logic signed [31:0] factor_ff;
   logic signed [8:0]  phase_ff;
   logic               reached_ff;

   assign rdy[NS] = !ov_ff || rsp_ch.ready;
   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_rdy
         assign rdy[k] = !v_ff[k] || rdy[k+1];
      end
   endgenerate
   assign req_ch.ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         ov_ff <= 1'b0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= req_ch.valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
         if (rdy[NS]) begin
            ov_ff <= v_ff[NS-1];
         end
      end
   end

   always_comb begin
      in_in.cmd            = req_ch.cmd;
      in_in.direction      = req_ch.direction;
      in_in.current_factor = req_ch.current_factor;
      in_in.param_one      = req_ch.param_one;
      in_in.param_two      = req_ch.param_two;
      in_in.phase_step     = req_ch.phase_step;
      in_in.target_factor  = req_ch.target_factor;
      in_in.sine_phase     = req_ch.sine_phase;
   end

   ess_prep u_prep (
      .req  (in_ff),
      .sb   (prep_sb),
      .op_a (op_a_in),
      .op_b (op_b_in)
   );

   // magnitude of the product, clamped where every kind saturates anyway
   always_comb begin
      mag    = prod_ff[65] ? 66'(-prod_ff) : 66'(prod_ff);
      capped = (mag >= PROD_CAP) ? PROD_CAP : mag;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         in_ff <= in_in;
      end
      if (rdy[1]) begin
         sb_ff[1] <= prep_sb;
         op_a_ff  <= op_a_in;
         op_b_ff  <= op_b_in;
      end
      if (rdy[2]) begin
         sb_ff[2] <= sb_ff[1];
         prod_ff  <= op_a_ff * op_b_ff;
      end
      if (rdy[3]) begin
         sb_ff[3]  <= sb_ff[2];
         neg_ff[3] <= prod_ff[65];
         rem_ff[3] <= '0;
         // divide by 8 here, the stages divide by 125
         x_ff[3]   <= DIV_WIDTH'(capped[43:3]);
      end
      for (int i = 4; i < NS; i++) begin
         if (rdy[i]) begin
            sb_ff[i]  <= sb_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
            rem_ff[i] <= rem_in[i-4];
            x_ff[i]   <= x_in[i-4];
         end
      end
      if (rdy[NS]) begin
         factor_ff  <= fin_factor;
         phase_ff   <= sb_ff[NS-1].phase;
         reached_ff <= fin_reached;
      end
   end

   generate
      for (k = 0; k < DIV_STAGES; k++) begin : g_div
         ess_div_stage u_div (
            .rem_i (rem_ff[k+3]),
            .x_i   (x_ff[k+3]),
            .rem_o (rem_in[k]),
            .x_o   (x_in[k])
         );
      end
   endgenerate

   ess_finish u_finish (
      .sb      (sb_ff[NS-1]),
      .neg     (neg_ff[NS-1]),
      .quot    (x_ff[NS-1][34:0]),
      .factor  (fin_factor),
      .reached (fin_reached)
   );

   assign rsp_ch.valid      = ov_ff;
   assign rsp_ch.new_factor = factor_ff;
   assign rsp_ch.new_phase  = phase_ff;
   assign rsp_ch.reached    = reached_ff;

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> v_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   a_last_to_out : assert property (@(posedge clock) disable iff (reset)
      v_ff[NS-1] && rdy[NS] |=> ov_ff)
      else $error("finished transaction did not reach the output register");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      v_ff[NS-1] && !rdy[NS] |=> v_ff[NS-1] && $stable(x_ff[NS-1]))
      else $error("last divide stage changed while stalled");

   a_reach_target : assert property (@(posedge clock) disable iff (reset)
      fin_reached |-> fin_factor == sb_ff[NS-1].target)
      else $error("reached result differs from target");

endmodule

>>> sv/ess_prep.sv
// ----------------------------------------------------------------------------
// ess_prep
// Operand selection, sine phase advance and table lookup, direct results
// ----------------------------------------------------------------------------
module ess_prep (
   input  ess_pkg::req_type    req,
   output ess_pkg::sb_type     sb,
   output logic signed [33:0]  op_a,
   output logic signed [31:0]  op_b
);
   import ess_pkg::*;

   logic signed [9:0]  ph_sum;
   logic signed [8:0]  ph_new;
   logic signed [9:0]  ph_wide;
   logic [9:0]         ph_mag;
   logic [7:0]         rom_idx;
   logic [18:0]        rom_val;
   logic signed [19:0] sine_val;
   logic signed [33:0] diff;
   logic signed [33:0] abs_diff;
   logic signed [31:0] lin_sum;

   always_comb begin
      ph_sum  = {req.sine_phase[8], req.sine_phase} + $signed({2'b00, req.phase_step});
      ph_new  = (ph_sum > 10'sd255) ? -9'sd255 : ph_sum[8:0];
      ph_wide = {ph_new[8], ph_new};
      ph_mag  = ph_wide[9] ? 10'(-ph_wide) : 10'(ph_wide);
      // magnitude mod 255
      if (ph_mag == 10'd255) begin
         rom_idx = 8'd0;
      end else if (ph_mag == 10'd256) begin
         rom_idx = 8'd1;
      end else begin
         rom_idx = ph_mag[7:0];
      end
      rom_val  = HALF_SINE[rom_idx];
      sine_val = ph_new[8] ? -$signed({1'b0, rom_val}) : $signed({1'b0, rom_val});

      diff     = $signed({{2{req.target_factor[31]}}, req.target_factor})
               - $signed({{2{req.current_factor[31]}}, req.current_factor});
      abs_diff = diff[33] ? -diff : diff;
      lin_sum  = sat32($signed({{6{req.current_factor[31]}}, req.current_factor})
                     + $signed({{6{req.param_one[31]}}, req.param_one}));

      op_b = req.param_one;
      sb.cmd        = req.cmd;
      sb.direction  = req.direction;
      sb.target     = req.target_factor;
      sb.offset     = req.param_two;
      sb.phase      = req.sine_phase;
      sb.rate_small = (req.param_one < 32'sd1000);
      sb.base       = req.current_factor;
      op_a          = '0;
      case (req.cmd)
         CMD_EXP: begin
            if (req.param_one > 32'sd1000 && req.current_factor < 32'sd1000) begin
               op_a = 34'sd1000;
            end else begin
               op_a = {{2{req.current_factor[31]}}, req.current_factor};
            end
         end
         CMD_INVEXP: op_a = abs_diff;
         CMD_LINEAR: sb.base = lin_sum;
         CMD_SINE: begin
            op_a     = {{14{sine_val[19]}}, sine_val};
            sb.phase = ph_new;
         end
         CMD_JUMP: sb.base = req.target_factor;
         default: sb.base = req.current_factor;
      endcase
   end

endmodule

>>> sv/ess_div_stage.sv
// ----------------------------------------------------------------------------
// ess_div_stage
// One radix 2^14 digit of division by 125 through a reciprocal multiply
// ----------------------------------------------------------------------------
module ess_div_stage (
   input  logic [6:0]                    rem_i,
   input  logic [ess_pkg::DIV_WIDTH-1:0] x_i,
   output logic [6:0]                    rem_o,
   output logic [ess_pkg::DIV_WIDTH-1:0] x_o
);
   import ess_pkg::*;

   logic [DIV_STEPS+6:0] part;
   logic [42:0]          prod;
   logic [DIV_STEPS-1:0] q;
   logic [DIV_STEPS+6:0] back;

   // quotient digit shifts in at the bottom as the dividend digit leaves the top
   always_comb begin
      part  = {rem_i, x_i[DIV_WIDTH-1 -: DIV_STEPS]};
      prod  = 43'(part) * 43'(DIV_RECIP);
      q     = prod[DIV_SHIFT +: DIV_STEPS];
      back  = (DIV_STEPS + 7)'(q) * (DIV_STEPS + 7)'(DIV_BY);
      rem_o = 7'(part - back);
      x_o   = {x_i[DIV_WIDTH-DIV_STEPS-1:0], q};
   end

endmodule

>>> sv/ess_finish.sv
// ----------------------------------------------------------------------------
// ess_finish
// Per-kind result from the scaled quotient, saturation and threshold test
// ----------------------------------------------------------------------------
module ess_finish (
   input  ess_pkg::sb_type     sb,
   input  logic                neg,
   input  logic [34:0]         quot,
   output logic signed [31:0]  factor,
   output logic                reached
);
   import ess_pkg::*;

   logic signed [37:0] qs;
   logic signed [37:0] dd;
   logic signed [37:0] sum;
   logic signed [31:0] f;

   always_comb begin
      qs = neg ? -$signed({3'b000, quot}) : $signed({3'b000, quot});
      dd = '0;
      sum = '0;
      case (sb.cmd)
         CMD_EXP: begin
            f = sat32(qs);
            if (sb.rate_small && f < 32'sd1000) begin
               f = '0;
            end
         end
         CMD_INVEXP: begin
            dd  = (qs < 38'sd10000) ? 38'sd0 : qs;
            sum = $signed({{6{sb.target[31]}}, sb.target}) - dd;
            f   = sat32(sum);
         end
         CMD_SINE: begin
            sum = qs + $signed({{6{sb.offset[31]}}, sb.offset});
            f   = sum[37] ? 32'sd0 : sat32(sum);
         end
         default: f = sb.base;
      endcase
      case (sb.direction)
         DIR_RISE: reached = (f >= sb.target);
         DIR_FALL: reached = (f <= sb.target);
         default:  reached = 1'b0;
      endcase
      factor = reached ? sb.target : f;
   end

endmodule
